/* hw/rtl/tpq_pkg.sv */
// Shared types and constants for the touch pen qualifier and mapper.
// No dependencies; every other file in hw/rtl but tpq_chan_if uses this package.
`timescale 1ns / 1ps
package tpq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = 12;
  localparam int GAIN_BITS   = 16;
  localparam int OFFS_BITS   = 20;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int HISTORY_BITS_DEF  = 8;

  localparam logic [SAMPLE_BITS-1:0] SPREAD_RST = SAMPLE_BITS'(20);
  localparam logic [GAIN_BITS-1:0]   GAIN_RST   = GAIN_BITS'(4096);

  typedef enum logic [2:0] {
    REG_CALIBRATED = 3'd0,
    REG_MAX_SPREAD = 3'd1,
    REG_X_GAIN     = 3'd2,
    REG_X_OFFSET   = 3'd3,
    REG_Y_GAIN     = 3'd4,
    REG_Y_OFFSET   = 3'd5
  } reg_idx_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]    pos_t;

  typedef struct packed {
    logic                         calibrated;
    sample_t                      max_spread;
    logic signed [GAIN_BITS-1:0]  x_gain;
    logic signed [OFFS_BITS-1:0]  x_offset;
    logic signed [GAIN_BITS-1:0]  y_gain;
    logic signed [OFFS_BITS-1:0]  y_offset;
  } cfg_t;

  typedef struct packed {
    logic    pen_level;
    sample_t x_first;
    sample_t y_first;
    sample_t x_second;
    sample_t y_second;
  } in_word_t;

  typedef struct packed {
    logic touching;
    logic press_event;
    logic release_event;
    logic sample_rejected;
    pos_t x_pos;
    pos_t y_pos;
    pos_t start_x;
    pos_t start_y;
  } out_word_t;

  // per-axis result: spread check and mapped position
  typedef struct packed {
    logic in_range;
    pos_t pos;
  } axis_res_t;

endpackage

/* hw/rtl/tpq_chan_if.sv */
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from tpq_pkg at instantiation.
`timescale 1ns / 1ps
interface tpq_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/tpq_regs.sv */
// APB-style configuration register file for the pen qualifier.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpq_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tpq_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tpq_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output tpq_pkg::cfg_t                  cfg
);
  import tpq_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calibrated <= 1'b0;
      cfg.max_spread <= SPREAD_RST;
      cfg.x_gain     <= GAIN_RST;
      cfg.x_offset   <= '0;
      cfg.y_gain     <= GAIN_RST;
      cfg.y_offset   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CALIBRATED: cfg.calibrated <= pwdata[0];
        REG_MAX_SPREAD: cfg.max_spread <= pwdata[SAMPLE_BITS-1:0];
        REG_X_GAIN:     cfg.x_gain     <= pwdata[GAIN_BITS-1:0];
        REG_X_OFFSET:   cfg.x_offset   <= pwdata[OFFS_BITS-1:0];
        REG_Y_GAIN:     cfg.y_gain     <= pwdata[GAIN_BITS-1:0];
        REG_Y_OFFSET:   cfg.y_offset   <= pwdata[OFFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CALIBRATED: prdata = DATA_BITS'(cfg.calibrated);
      REG_MAX_SPREAD: prdata = DATA_BITS'(cfg.max_spread);
      REG_X_GAIN:     prdata = DATA_BITS'(cfg.x_gain);
      REG_X_OFFSET:   prdata = DATA_BITS'(cfg.x_offset);
      REG_Y_GAIN:     prdata = DATA_BITS'(cfg.y_gain);
      REG_Y_OFFSET:   prdata = DATA_BITS'(cfg.y_offset);
      default:        prdata = '0;
    endcase
  end
endmodule

/* hw/rtl/tpq_axis.sv */
// One axis: spread check, average of two samples, optional gain/offset
// mapping with clamp to 0..SIZE-1. Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_axis #(
  parameter int SIZE = tpq_pkg::SCREEN_WIDTH_DEF
) (
  input  tpq_pkg::sample_t                     a,
  input  tpq_pkg::sample_t                     b,
  input  tpq_pkg::sample_t                     max_spread,
  input  logic                                 calibrated,
  input  logic signed [tpq_pkg::GAIN_BITS-1:0] gain,
  input  logic signed [tpq_pkg::OFFS_BITS-1:0] offset,
  output tpq_pkg::axis_res_t                   res
);
  import tpq_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + 1 + GAIN_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int PIX_BITS  = SUM_BITS - 1 - 12;
  localparam logic [PIX_BITS-1:0] LIMIT = PIX_BITS'(SIZE - 1);

  sample_t                      diff;
  logic [SAMPLE_BITS:0]         pair_sum;
  sample_t                      avg;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [SUM_BITS-1:0]   total;
  logic [PIX_BITS-1:0]          pix;
  pos_t                         mapped;

  assign diff     = (a > b) ? (a - b) : (b - a);
  assign pair_sum = {1'b0, a} + {1'b0, b};
  assign avg      = pair_sum[SAMPLE_BITS:1];

  // Q.12 value: avg * gain + offset * 256
  assign prod  = PROD_BITS'($signed({1'b0, avg})) * PROD_BITS'(gain);
  assign total = SUM_BITS'(prod) + (SUM_BITS'(offset) <<< 8);
  assign pix   = total[SUM_BITS-2:12];

  always_comb begin
    if (total[SUM_BITS-1]) begin
      mapped = '0;
    end else if (pix >= LIMIT) begin
      mapped = POS_BITS'(LIMIT);
    end else begin
      mapped = POS_BITS'(pix);
    end
  end

  assign res.in_range = (diff <= max_spread);
  assign res.pos      = calibrated ? mapped : POS_BITS'(avg);
endmodule

/* hw/rtl/touch_pen_qualifier_and_mapper.sv */
// Top level: pen debounce history, press/release tracking and position
// mapping. Depends on tpq_pkg, tpq_chan_if, tpq_regs and tpq_axis.
//
//   channel   dir  payload      handshake
//   pen_in    in   in_word_t    valid/ready, taken when both high
//   pos_out   out  out_word_t   valid/ready, taken when both high
//   apb       in   32-bit regs  psel/penable/pwrite, pready tied high
//
// One word in, one word out. Each word passes an input register,
// then the history/spread/multiply-add logic, then the output register.
// Throughput is one word per cycle while pos_out is not stalled; the state
// (history, held, positions) is updated as a word leaves the input register.
// Reset (rst, synchronous) empties both registers, sets the history to
// all ones and clears held and the positions.
// A stalled output holds; the input register still drains into the output
// slot as soon as it frees, so pen_in.ready only drops while both are full
// and pos_out.ready is low.
`timescale 1ns / 1ps
module touch_pen_qualifier_and_mapper #(
  parameter int SCREEN_WIDTH  = tpq_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tpq_pkg::SCREEN_HEIGHT_DEF,
  parameter int HISTORY_BITS  = tpq_pkg::HISTORY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpq_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tpq_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tpq_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  tpq_chan_if.sink                       pen_in,
  tpq_chan_if.source                     pos_out
);
  import tpq_pkg::*;

  cfg_t cfg;

  // input register
  logic     s1_valid;
  in_word_t s1_word;
  logic     s1_adv;

  // output register
  logic      out_valid;
  out_word_t out_word;
  out_word_t res;

  // debounce / press state
  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS-1:0] history_next;
  logic                    held;
  logic                    held_next;
  pos_t                    last_x, last_y, first_x, first_y;
  pos_t                    last_x_next, last_y_next, first_x_next, first_y_next;

  axis_res_t x_res, y_res;
  logic      stable, released_hist, pos_ok, take_pos, press;

  tpq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpq_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
    .a          (s1_word.x_first),
    .b          (s1_word.x_second),
    .max_spread (cfg.max_spread),
    .calibrated (cfg.calibrated),
    .gain       (cfg.x_gain),
    .offset     (cfg.x_offset),
    .res        (x_res)
  );

  tpq_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
    .a          (s1_word.y_first),
    .b          (s1_word.y_second),
    .max_spread (cfg.max_spread),
    .calibrated (cfg.calibrated),
    .gain       (cfg.y_gain),
    .offset     (cfg.y_offset),
    .res        (y_res)
  );

  // handshake: input register drains whenever the output slot is free
  assign s1_adv       = s1_valid && (!out_valid || pos_out.ready);
  assign pen_in.ready = !s1_valid || s1_adv;

  assign pos_out.valid   = out_valid;
  assign pos_out.payload = out_word;

  // qualification
  assign history_next  = {history[HISTORY_BITS-2:0], s1_word.pen_level};
  assign stable        = (history_next == '0);
  assign released_hist = &history_next;
  assign pos_ok        = x_res.in_range && y_res.in_range;
  assign take_pos      = stable && pos_ok;
  assign press         = take_pos && !held;

  always_comb begin
    held_next    = held;
    last_x_next  = last_x;
    last_y_next  = last_y;
    first_x_next = first_x;
    first_y_next = first_y;
    if (take_pos) begin
      held_next   = 1'b1;
      last_x_next = x_res.pos;
      last_y_next = y_res.pos;
    end else if (released_hist) begin
      held_next = 1'b0;
    end
    if (press) begin
      first_x_next = x_res.pos;
      first_y_next = y_res.pos;
    end
  end

  always_comb begin
    res.touching        = held_next;
    res.press_event     = press;
    res.release_event   = released_hist && held;  // no event if never held
    res.sample_rejected = stable && !pos_ok;
    res.x_pos           = last_x_next;
    res.y_pos           = last_y_next;
    res.start_x         = first_x_next;
    res.start_y         = first_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      history   <= '1;
      held      <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
      first_x   <= '0;
      first_y   <= '0;
    end else begin
      if (pen_in.valid && pen_in.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
        history   <= history_next;
        held      <= held_next;
        last_x    <= last_x_next;
        last_y    <= last_y_next;
        first_x   <= first_x_next;
        first_y   <= first_y_next;
      end else if (pos_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pen_in.valid && pen_in.ready) begin
      s1_word <= pen_in.payload;
    end
    if (s1_adv) begin
      out_word <= res;
    end
  end
endmodule

/* hw/rtl/tpq_checker.sv */
// Port-level checks for touch_pen_qualifier_and_mapper, attached by bind.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tpq_pkg::out_word_t out_word
);
  import tpq_pkg::*;

  // an empty output slot never blocks the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output slot");

  // a press is held and starts where the position is
  a_press_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.press_event |->
      out_word.touching && !out_word.sample_rejected &&
      out_word.start_x == out_word.x_pos && out_word.start_y == out_word.y_pos)
    else $error("press word inconsistent");

  // a release leaves nothing held and never pairs with a press
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.release_event |->
      !out_word.touching && !out_word.press_event)
    else $error("release word inconsistent");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");
endmodule

bind touch_pen_qualifier_and_mapper tpq_checker u_tpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pen_in.ready),
  .out_valid (pos_out.valid),
  .out_ready (pos_out.ready),
  .out_word  (pos_out.payload)
);
